// ----- rtl/core/qspims_pkg.sv -----
// Shared types and constants for the quad SPI master shifter.
// Used by qspi_master_shifter; depends on nothing else.
`default_nettype none

package qspims_pkg;

    // Phase operation codes carried in s_tuser
    typedef enum logic [2:0] {
        OP_CMD    = 3'd0,
        OP_ADDR   = 3'd1,
        OP_WRITE  = 3'd2,
        OP_READ   = 3'd3,
        OP_DUMMY  = 3'd4,
        OP_DUPLEX = 3'd5,
        OP_SELECT = 3'd6,
        OP_DESEL  = 3'd7
    } op_t;

    // Bus mode register codes (6 and 7 behave as standard)
    localparam logic [2:0] BUS_STD      = 3'd0;
    localparam logic [2:0] BUS_DUAL_OUT = 3'd1;
    localparam logic [2:0] BUS_DUAL_IO  = 3'd2;
    localparam logic [2:0] BUS_QUAD_OUT = 3'd3;
    localparam logic [2:0] BUS_QUAD_IO  = 3'd4;
    localparam logic [2:0] BUS_QPI      = 3'd5;

    // Lane width of a phase
    typedef enum logic [1:0] {
        LANE_1 = 2'd0,
        LANE_2 = 2'd1,
        LANE_4 = 2'd2
    } lane_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    localparam int          MAX_DUMMY   = 32;
    localparam int          CNT_W       = 6;
    localparam logic [3:0]  DIR_RESET   = 4'hD;
    localparam logic [3:0]  LEVEL_RESET = 4'hC;
    localparam int          S_DATA_W    = 80;
    localparam int          M_DATA_W    = 24;

    // io lines used by a lane width
    function automatic logic [3:0] lane_mask(input lane_t w);
        case (w)
            LANE_2:  lane_mask = 4'h3;
            LANE_4:  lane_mask = 4'hF;
            default: lane_mask = 4'h1;
        endcase
    endfunction

    // Clocks to move one byte at a lane width
    function automatic logic [CNT_W-1:0] byte_clocks(input lane_t w);
        case (w)
            LANE_2:  byte_clocks = CNT_W'(4);
            LANE_4:  byte_clocks = CNT_W'(2);
            default: byte_clocks = CNT_W'(8);
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/qspi_master_shifter.sv -----
// Quad SPI master shifter: one phase operation in, one item per serial clock out.
// Depends on qspims_pkg.
// The accepting edge latches the operation; each result item is registered when the run state steps.
// An operation yields N items (1 to 32); the shared
// shift/sample unit produces one item per cycle while m_tready allows.
// Not ready for a new operation until its last item has been produced.
// Reset (aresetn low, synchronous): bus mode standard, io0/io2/io3 driven,
// io1 released, io2 and io3 high, chip deselected, no item pending.
`default_nettype none

module qspi_master_shifter
    import qspims_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration
    input  wire logic                cfg_wr_en,
    input  wire logic [2:0]          cfg_wr_data,   // bus_mode
    // operation input
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    // tx_byte[7:0], address[39:8], address_wide[40], dummy_count[46:41],
    // line_samples[78:47], zero[79]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [2:0]          s_tuser,       // mode
    // result items
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    // cs_n[0], io_drive[4:1], io_enable[8:5], rx_byte[16:9], zero[23:17]
    output      logic [M_DATA_W-1:0] m_tdata,
    output      logic                m_tuser,       // clock_pulse
    output      logic                m_tlast        // last
);

    // input fields
    op_t         in_op;
    logic [7:0]  in_tx;
    logic [31:0] in_addr;
    logic        in_wide;
    logic [5:0]  in_dummy;
    logic [31:0] in_samples;

    assign in_op      = op_t'(s_tuser);
    assign in_tx      = s_tdata[7:0];
    assign in_addr    = s_tdata[39:8];
    assign in_wide    = s_tdata[40];
    assign in_dummy   = s_tdata[46:41];
    assign in_samples = s_tdata[78:47];

    // state
    state_t            state_reg, state_next;
    logic [2:0]        bus_mode_reg;
    logic [3:0]        dir_reg, dir_next;
    logic [3:0]        level_reg, level_next;
    logic              sel_reg, sel_next;
    lane_t             lane_reg, lane_next;
    logic [31:0]       shift_reg, shift_next;
    logic [31:0]       samp_reg, samp_next;
    logic [7:0]        rx_reg, rx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              tx_en_reg, tx_en_next;
    logic              rx_en_reg, rx_en_next;
    logic              clk_en_reg, clk_en_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic              m_clk_reg, m_clk_next;
    logic              m_last_reg, m_last_next;

    logic              accept;
    logic              step;
    logic              run_done;

    // lane width per phase from the bus mode
    lane_t lane_cmd, lane_addr, lane_data;

    always_comb begin
        lane_cmd = (bus_mode_reg == BUS_QPI) ? LANE_4 : LANE_1;
        case (bus_mode_reg)
            BUS_DUAL_IO:             lane_addr = LANE_2;
            BUS_QUAD_IO, BUS_QPI:    lane_addr = LANE_4;
            default:                 lane_addr = LANE_1;
        endcase
        case (bus_mode_reg)
            BUS_DUAL_OUT, BUS_DUAL_IO:          lane_data = LANE_2;
            BUS_QUAD_OUT, BUS_QUAD_IO, BUS_QPI: lane_data = LANE_4;
            default:                            lane_data = LANE_1;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (run_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        step     = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_RUN:  step     = !m_valid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
                step     = 1'b0;
            end
        endcase
    end

    assign accept   = s_tvalid && s_tready;
    assign run_done = step && (cnt_reg == CNT_W'(1));

    // operation setup and shared shift/sample unit
    always_comb begin
        logic [3:0] m;
        logic [3:0] bits;
        logic [3:0] nib;
        logic [3:0] level_step;
        logic [7:0] rx_step;
        logic [5:0] dummy_sat;

        dir_next    = dir_reg;
        level_next  = level_reg;
        sel_next    = sel_reg;
        lane_next   = lane_reg;
        shift_next  = shift_reg;
        samp_next   = samp_reg;
        rx_next     = rx_reg;
        cnt_next    = cnt_reg;
        tx_en_next  = tx_en_reg;
        rx_en_next  = rx_en_reg;
        clk_en_next = clk_en_reg;

        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_clk_next   = m_clk_reg;
        m_last_next  = m_last_reg;

        dummy_sat = (in_dummy > 6'(MAX_DUMMY)) ? 6'(MAX_DUMMY) : in_dummy;

        // latch an operation and set line directions
        if (accept) begin
            samp_next   = in_samples;
            rx_next     = 8'h00;
            shift_next  = {in_tx, 24'h000000};
            tx_en_next  = 1'b0;
            rx_en_next  = 1'b0;
            clk_en_next = 1'b1;
            lane_next   = LANE_1;
            cnt_next    = CNT_W'(1);
            unique case (in_op)
                OP_CMD: begin
                    lane_next  = lane_cmd;
                    tx_en_next = 1'b1;
                    cnt_next   = byte_clocks(lane_cmd);
                    dir_next   = dir_reg | lane_mask(lane_cmd);
                end
                OP_ADDR: begin
                    lane_next  = lane_addr;
                    tx_en_next = 1'b1;
                    shift_next = in_wide ? in_addr : {in_addr[23:0], 8'h00};
                    // 3 or 4 bytes
                    cnt_next   = in_wide ? CNT_W'({byte_clocks(lane_addr), 2'b00} >> 0)
                                         : CNT_W'(byte_clocks(lane_addr) * 3);
                    dir_next   = dir_reg | lane_mask(lane_addr);
                end
                OP_WRITE: begin
                    lane_next  = lane_data;
                    tx_en_next = 1'b1;
                    cnt_next   = byte_clocks(lane_data);
                    dir_next   = dir_reg | lane_mask(lane_data);
                end
                OP_READ: begin
                    lane_next  = lane_data;
                    rx_en_next = 1'b1;
                    cnt_next   = byte_clocks(lane_data);
                    // single lane listens on io1 only
                    if (lane_data == LANE_1) begin
                        dir_next = dir_reg & ~4'h2;
                    end else begin
                        dir_next = dir_reg & ~lane_mask(lane_data);
                    end
                end
                OP_DUMMY: begin
                    dir_next = 4'h0;
                    if (dummy_sat == 6'd0) begin
                        clk_en_next = 1'b0;
                        cnt_next    = CNT_W'(1);
                    end else begin
                        cnt_next    = dummy_sat;
                    end
                end
                OP_DUPLEX: begin
                    tx_en_next = 1'b1;
                    rx_en_next = 1'b1;
                    cnt_next   = CNT_W'(8);
                    dir_next   = (dir_reg | 4'h1) & ~4'h2;
                end
                OP_SELECT: begin
                    clk_en_next = 1'b0;
                    sel_next    = 1'b0;
                end
                OP_DESEL: begin
                    clk_en_next = 1'b0;
                    sel_next    = 1'b1;
                end
                default: clk_en_next = 1'b0;
            endcase
        end

        // one serial clock per step when the clock is enabled
        m   = lane_mask(lane_reg);
        nib = samp_reg[3:0];
        case (lane_reg)
            LANE_2: begin
                bits    = {2'b00, shift_reg[31:30]};
                rx_step = {rx_reg[5:0], nib[1:0]};
            end
            LANE_4: begin
                bits    = shift_reg[31:28];
                rx_step = {rx_reg[3:0], nib};
            end
            default: begin
                bits    = {3'b000, shift_reg[31]};
                rx_step = {rx_reg[6:0], nib[1]};
            end
        endcase
        level_step = tx_en_reg ? ((level_reg & ~m) | bits) : level_reg;

        if (step) begin
            level_next = level_step;
            if (rx_en_reg) begin
                rx_next = rx_step;
            end
            case (lane_reg)
                LANE_2:  shift_next = {shift_reg[29:0], 2'b00};
                LANE_4:  shift_next = {shift_reg[27:0], 4'h0};
                default: shift_next = {shift_reg[30:0], 1'b0};
            endcase
            samp_next = {4'h0, samp_reg[31:4]};
            cnt_next  = cnt_reg - CNT_W'(1);

            m_valid_next = 1'b1;
            m_clk_next   = clk_en_reg;
            m_last_next  = (cnt_reg == CNT_W'(1));
            m_data_next  = {7'h00,
                            (rx_en_reg && cnt_reg == CNT_W'(1)) ? rx_step : 8'h00,
                            dir_reg,
                            level_step & dir_reg,
                            sel_reg};
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bus_mode_reg <= BUS_STD;
            dir_reg      <= DIR_RESET;
            level_reg    <= LEVEL_RESET;
            sel_reg      <= 1'b1;
            m_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
            tx_en_reg    <= 1'b0;
            rx_en_reg    <= 1'b0;
            clk_en_reg   <= 1'b0;
            lane_reg     <= LANE_1;
        end else begin
            state_reg   <= state_next;
            if (cfg_wr_en) begin
                bus_mode_reg <= cfg_wr_data;
            end
            dir_reg     <= dir_next;
            level_reg   <= level_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            tx_en_reg   <= tx_en_next;
            rx_en_reg   <= rx_en_next;
            clk_en_reg  <= clk_en_next;
            lane_reg    <= lane_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        shift_reg  <= shift_next;
        samp_reg   <= samp_next;
        rx_reg     <= rx_next;
        m_data_reg <= m_data_next;
        m_clk_reg  <= m_clk_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_clk_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
